/* sv/u8d_pkg.sv */
// shared types and constants for the utf-8 decoder with identifier classification
// holds the beat structs, byte-format codes and the identifier range tables
// no dependencies
`timescale 1ns / 1ps

package u8d_pkg;

   // byte-format codes
   localparam logic [1:0] CONT_TAG   = 2'b10;
   localparam logic [7:0] ASCII_TOP  = 8'h80;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD2_MIN  = 8'hC0;

   localparam int CP_W  = 21;
   localparam int LEN_W = 3;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   // one decoded result between the decode and classify stages
   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             is_error;
   } u8d_beat_type;

   // identifier flags from the classifier
   typedef struct packed {
      logic ident_start;
      logic ident_continue;
   } u8d_class_type;

   typedef struct packed {
      logic [CP_W-1:0] lo;
      logic [CP_W-1:0] hi;
   } u8d_range_type;

   localparam int START_N = 53;
   localparam int CONT_N  = 6;

   // code points allowed as the first identifier character
   localparam u8d_range_type START_RANGES [START_N] = '{
      '{21'h00005F, 21'h00005F}, '{21'h000061, 21'h00007A},
      '{21'h000041, 21'h00005A}, '{21'h000024, 21'h000024},
      '{21'h0000A8, 21'h0000A8}, '{21'h0000AA, 21'h0000AA},
      '{21'h0000AD, 21'h0000AD}, '{21'h0000AF, 21'h0000AF},
      '{21'h0000B2, 21'h0000B5}, '{21'h0000B7, 21'h0000BA},
      '{21'h0000BC, 21'h0000BE}, '{21'h0000C0, 21'h0000D6},
      '{21'h0000D8, 21'h0000F6}, '{21'h0000F8, 21'h0000FF},
      '{21'h000100, 21'h0002FF}, '{21'h000370, 21'h00167F},
      '{21'h001681, 21'h00180D}, '{21'h00180F, 21'h001DBF},
      '{21'h001E00, 21'h001FFF}, '{21'h00200B, 21'h00200D},
      '{21'h00202A, 21'h00202E}, '{21'h00203F, 21'h002040},
      '{21'h002054, 21'h002054}, '{21'h002060, 21'h00206F},
      '{21'h002070, 21'h0020CF}, '{21'h002100, 21'h00218F},
      '{21'h002460, 21'h0024FF}, '{21'h002776, 21'h002793},
      '{21'h002C00, 21'h002DFF}, '{21'h002E80, 21'h002FFF},
      '{21'h003004, 21'h003007}, '{21'h003021, 21'h00302F},
      '{21'h003031, 21'h00303F}, '{21'h003040, 21'h00D7FF},
      '{21'h00F900, 21'h00FD3D}, '{21'h00FD40, 21'h00FDCF},
      '{21'h00FDF0, 21'h00FE1F}, '{21'h00FE30, 21'h00FE44},
      '{21'h00FE47, 21'h00FFFD},
      '{21'h010000, 21'h01FFFD}, '{21'h020000, 21'h02FFFD},
      '{21'h030000, 21'h03FFFD}, '{21'h040000, 21'h04FFFD},
      '{21'h050000, 21'h05FFFD}, '{21'h060000, 21'h06FFFD},
      '{21'h070000, 21'h07FFFD}, '{21'h080000, 21'h08FFFD},
      '{21'h090000, 21'h09FFFD}, '{21'h0A0000, 21'h0AFFFD},
      '{21'h0B0000, 21'h0BFFFD}, '{21'h0C0000, 21'h0CFFFD},
      '{21'h0D0000, 21'h0DFFFD}, '{21'h0E0000, 21'h0EFFFD}
   };

   // extra code points allowed after the first identifier character (24h is also a start range)
   localparam u8d_range_type CONT_RANGES [CONT_N] = '{
      '{21'h000030, 21'h000039}, '{21'h000024, 21'h000024},
      '{21'h000300, 21'h00036F}, '{21'h001DC0, 21'h001DFF},
      '{21'h0020D0, 21'h0020FF}, '{21'h00FE20, 21'h00FE2F}
   };

endpackage

/* sv/u8d_ident_class.sv */
// identifier classifier: parallel range compares on one code point
// depends on u8d_pkg for the range tables and the flag struct
`timescale 1ns / 1ps

module u8d_ident_class
   import u8d_pkg::*;
(
   input  logic [CP_W-1:0] code_point,
   input  logic            is_error,
   output u8d_class_type   flags
);

   logic start_hit;
   logic cont_hit;

   // one compare pair per range, or-reduced
   always_comb begin
      start_hit = 1'b0;
      for (int i = 0; i < START_N; i++) begin
         if (code_point >= START_RANGES[i].lo && code_point <= START_RANGES[i].hi) begin
            start_hit = 1'b1;
         end
      end
   end

   always_comb begin
      cont_hit = 1'b0;
      for (int i = 0; i < CONT_N; i++) begin
         if (code_point >= CONT_RANGES[i].lo && code_point <= CONT_RANGES[i].hi) begin
            cont_hit = 1'b1;
         end
      end
   end

   // error beats carry no flags
   assign flags.ident_start    = !is_error && start_hit;
   assign flags.ident_continue = !is_error && (start_hit || cont_hit);

endmodule

/* sv/utf8_decoder_ident_classifier.sv */
// utf-8 byte stream decoder with identifier start/continue classification
// depends on u8d_pkg and u8d_ident_class
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_byte_in[7:0]
//   rsp       out        rsp_valid/rsp_stall  code_point, seq_length, is_error, ident flags
//
// one byte accepted per cycle while req_stall is low; results pass both stage registers
// stage one decodes into the beat register, stage two classifies into the output register
// reset clears the open sequence and both valid flags
// each stage holds while the stage after it is full and stalled; req_stall rises
// only when both stages hold a beat and rsp_stall is high
`timescale 1ns / 1ps

module utf8_decoder_ident_classifier
   import u8d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_byte_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CP_W-1:0]  rsp_code_point,
   output logic [LEN_W-1:0] rsp_seq_length,
   output logic             rsp_is_error,
   output logic             rsp_ident_start,
   output logic             rsp_ident_continue
);

   // decode state
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [1:0]       remain_ff, remain_in;
   logic [LEN_W-1:0] len_ff, len_in;

   // stage registers
   logic             beat_valid_ff, beat_valid_in;
   u8d_beat_type     beat_ff, beat_in;
   logic             out_valid_ff;
   u8d_beat_type     out_ff;
   u8d_class_type    out_flags_ff;

   logic             req_acc;
   logic             out_en;
   logic             beat_en;
   logic [CP_W-1:0]  shifted;
   u8d_class_type    flags;

   // stage enables
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign beat_en   = !beat_valid_ff || out_en;
   assign req_stall = !beat_en;
   assign req_acc   = req_valid && beat_en;

   assign shifted = {partial_ff[CP_W-7:0], req_byte_in[5:0]};

   // byte decode
   always_comb begin
      partial_in    = partial_ff;
      remain_in     = remain_ff;
      len_in        = len_ff;
      beat_valid_in = 1'b0;
      beat_in       = '0;
      if (req_acc) begin
         if (remain_ff != 2'd0) begin
            if (req_byte_in[7:6] != CONT_TAG) begin
               // bad continuation drops the sequence and this byte
               beat_valid_in      = 1'b1;
               beat_in.is_error   = 1'b1;
               beat_in.seq_length = len_ff - {1'b0, remain_ff} + LEN_ONE;
               partial_in         = '0;
               remain_in          = 2'd0;
               len_in             = '0;
            end else if (remain_ff == 2'd1) begin
               beat_valid_in      = 1'b1;
               beat_in.code_point = shifted;
               beat_in.seq_length = len_ff;
               partial_in         = '0;
               remain_in          = 2'd0;
               len_in             = '0;
            end else begin
               partial_in = shifted;
               remain_in  = remain_ff - 2'd1;
            end
         end else begin
            priority if (req_byte_in < ASCII_TOP) begin
               beat_valid_in      = 1'b1;
               beat_in.code_point = {{(CP_W-8){1'b0}}, req_byte_in};
               beat_in.seq_length = LEN_ONE;
            end else if (req_byte_in >= LEAD4_MIN) begin
               partial_in = {{(CP_W-3){1'b0}}, req_byte_in[2:0]};
               len_in     = LEN_FOUR;
               remain_in  = 2'd3;
            end else if (req_byte_in >= LEAD3_MIN) begin
               partial_in = {{(CP_W-4){1'b0}}, req_byte_in[3:0]};
               len_in     = LEN_THREE;
               remain_in  = 2'd2;
            end else if (req_byte_in >= LEAD2_MIN) begin
               partial_in = {{(CP_W-5){1'b0}}, req_byte_in[4:0]};
               len_in     = LEN_TWO;
               remain_in  = 2'd1;
            end else begin
               // stray continuation byte
               beat_valid_in      = 1'b1;
               beat_in.is_error   = 1'b1;
               beat_in.seq_length = LEN_ONE;
            end
         end
      end
   end

   // decode state and beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         remain_ff     <= 2'd0;
         len_ff        <= '0;
         beat_valid_ff <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         len_ff     <= len_in;
         if (beat_en) begin
            beat_valid_ff <= beat_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_en) begin
         beat_ff <= beat_in;
      end
   end

   // identifier classification
   u8d_ident_class u_class (
      .code_point (beat_ff.code_point),
      .is_error   (beat_ff.is_error),
      .flags      (flags)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= beat_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff       <= beat_ff;
         out_flags_ff <= flags;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_code_point     = out_ff.code_point;
   assign rsp_seq_length     = out_ff.seq_length;
   assign rsp_is_error       = out_ff.is_error;
   assign rsp_ident_start    = out_flags_ff.ident_start;
   assign rsp_ident_continue = out_flags_ff.ident_continue;

   // error beats carry a zero code point and no flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |->
         rsp_code_point == '0 && !rsp_ident_start && !rsp_ident_continue)
      else $error("error beat with payload");

   // a start character is always a continue character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ident_start |-> rsp_ident_continue)
      else $error("ident_start without ident_continue");

   // sequence length stays within one to four
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seq_length != '0 && rsp_seq_length <= LEN_FOUR)
      else $error("bad sequence length");

   // an open sequence has fewer bytes due than its length
   assert property (@(posedge clock) disable iff (reset)
      remain_ff != 2'd0 |-> len_ff >= LEN_TWO && {1'b0, remain_ff} < len_ff)
      else $error("inconsistent decode state");

   // the input side stalls only when both stages are full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> beat_valid_ff && out_valid_ff && rsp_stall)
      else $error("stall with free stage");

endmodule

/* tb/sv/testbench.sv */
// self-checking bench for utf8_decoder_ident_classifier: byte stream in, decoded characters out
// a scoreboard class predicts each character and its identifier flags; plain tasks drive the block
// depends on u8d_pkg and the decoder rtl
`timescale 1ns / 1ps

module testbench;
   import u8d_pkg::*;

   // one decoded character as it leaves the block
   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             is_error;
      logic             ident_start;
      logic             ident_continue;
   } decoded_char_type;

   // identifier-start ranges inside the basic multilingual plane
   localparam int BMP_START_N = 39;
   localparam int unsigned BMP_START [BMP_START_N][2] = '{
      '{'h005F, 'h005F}, '{'h0061, 'h007A}, '{'h0041, 'h005A}, '{'h0024, 'h0024},
      '{'h00A8, 'h00A8}, '{'h00AA, 'h00AA}, '{'h00AD, 'h00AD}, '{'h00AF, 'h00AF},
      '{'h00B2, 'h00B5}, '{'h00B7, 'h00BA}, '{'h00BC, 'h00BE}, '{'h00C0, 'h00D6},
      '{'h00D8, 'h00F6}, '{'h00F8, 'h00FF}, '{'h0100, 'h02FF}, '{'h0370, 'h167F},
      '{'h1681, 'h180D}, '{'h180F, 'h1DBF}, '{'h1E00, 'h1FFF}, '{'h200B, 'h200D},
      '{'h202A, 'h202E}, '{'h203F, 'h2040}, '{'h2054, 'h2054}, '{'h2060, 'h206F},
      '{'h2070, 'h20CF}, '{'h2100, 'h218F}, '{'h2460, 'h24FF}, '{'h2776, 'h2793},
      '{'h2C00, 'h2DFF}, '{'h2E80, 'h2FFF}, '{'h3004, 'h3007}, '{'h3021, 'h302F},
      '{'h3031, 'h303F}, '{'h3040, 'hD7FF}, '{'hF900, 'hFD3D}, '{'hFD40, 'hFDCF},
      '{'hFDF0, 'hFE1F}, '{'hFE30, 'hFE44}, '{'hFE47, 'hFFFD}
   };

   // ranges allowed after the first identifier character (24h is also a start range)
   localparam int CONT_ONLY_N = 6;
   localparam int unsigned CONT_ONLY [CONT_ONLY_N][2] = '{
      '{'h0030, 'h0039}, '{'h0024, 'h0024}, '{'h0300, 'h036F},
      '{'h1DC0, 'h1DFF}, '{'h20D0, 'h20FF}, '{'hFE20, 'hFE2F}
   };

   // corner bytes: ascii ends, digit, stray continuation, all lengths, bad continuations
   localparam int DIRECTED_N = 25;
   localparam logic [7:0] DIRECTED_BYTES [DIRECTED_N] = '{
      8'h00, 8'h7F, 8'h30, 8'h80,
      8'hDF, 8'hBF,
      8'hE0, 8'h80, 8'h80,
      8'hEF, 8'hBF, 8'hBF,
      8'hFF, 8'hBF, 8'hBF, 8'hBF,
      8'hC3, 8'h41,
      8'hE2, 8'h82, 8'hC3,
      8'hF0, 8'h90, 8'h80, 8'h28
   };

   // decoder state mirror and queue of characters still owed by the block
   class utf8_char_scoreboard;
      logic [CP_W-1:0]  partial_cp;
      logic [1:0]       cont_left;
      logic [LEN_W-1:0] open_len;
      decoded_char_type expected_chars [$];
      int fail_count;
      int char_count;
      int error_count;
      int start_count;

      function new();
         clear_open();
         fail_count  = 0;
         char_count  = 0;
         error_count = 0;
         start_count = 0;
      endfunction

      function void clear_open();
         partial_cp = '0;
         cont_left  = '0;
         open_len   = '0;
      endfunction

      function bit starts_ident(logic [CP_W-1:0] cp);
         if (cp >= 21'h10000 && cp[20:16] <= 5'd14 && cp[15:0] <= 16'hFFFD) return 1'b1;
         for (int i = 0; i < BMP_START_N; i++)
            if (cp >= BMP_START[i][0] && cp <= BMP_START[i][1]) return 1'b1;
         return 1'b0;
      endfunction

      function bit continues_ident(logic [CP_W-1:0] cp);
         if (starts_ident(cp)) return 1'b1;
         for (int i = 0; i < CONT_ONLY_N; i++)
            if (cp >= CONT_ONLY[i][0] && cp <= CONT_ONLY[i][1]) return 1'b1;
         return 1'b0;
      endfunction

      function void push_char(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic err);
         decoded_char_type c;
         c.code_point     = err ? '0 : cp;
         c.seq_length     = len;
         c.is_error       = err;
         c.ident_start    = err ? 1'b0 : starts_ident(cp);
         c.ident_continue = err ? 1'b0 : continues_ident(cp);
         expected_chars.push_back(c);
      endfunction

      // accepted input beat: advance the mirror and queue any finished character
      function void note_byte(logic [7:0] b);
         logic [LEN_W-1:0] got;
         if (cont_left != 0) begin
            got = open_len - LEN_W'(cont_left);
            if (b[7:6] != CONT_TAG) begin
               push_char('0, got + LEN_ONE, 1'b1);
               clear_open();
               return;
            end
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left == 0) begin
               push_char(partial_cp, open_len, 1'b0);
               clear_open();
            end
            return;
         end
         if (b < ASCII_TOP) begin
            push_char(CP_W'(b), LEN_ONE, 1'b0);
            return;
         end
         if (b >= LEAD4_MIN) begin
            partial_cp = CP_W'(b[2:0]);
            open_len   = LEN_FOUR;
         end else if (b >= LEAD3_MIN) begin
            partial_cp = CP_W'(b[3:0]);
            open_len   = LEN_THREE;
         end else if (b >= LEAD2_MIN) begin
            partial_cp = CP_W'(b[4:0]);
            open_len   = LEN_TWO;
         end else begin
            // stray continuation
            push_char('0, LEN_ONE, 1'b1);
            return;
         end
         cont_left = 2'(open_len - LEN_ONE);
      endfunction

      // output beat: compare against the oldest owed character
      function void check_char(decoded_char_type got);
         decoded_char_type want;
         bit bad;
         if (expected_chars.size() == 0) begin
            $error("unexpected result: code_point %h seq_length %0d is_error %0d",
                   got.code_point, got.seq_length, got.is_error);
            fail_count++;
            return;
         end
         want = expected_chars.pop_front();
         bad  = 1'b0;
         if (got.code_point !== want.code_point) begin
            $error("code_point expected %h actual %h", want.code_point, got.code_point);
            bad = 1'b1;
         end
         if (got.seq_length !== want.seq_length) begin
            $error("seq_length expected %0d actual %0d", want.seq_length, got.seq_length);
            bad = 1'b1;
         end
         if (got.is_error !== want.is_error) begin
            $error("is_error expected %0d actual %0d", want.is_error, got.is_error);
            bad = 1'b1;
         end
         if (got.ident_start !== want.ident_start) begin
            $error("ident_start expected %0d actual %0d", want.ident_start, got.ident_start);
            bad = 1'b1;
         end
         if (got.ident_continue !== want.ident_continue) begin
            $error("ident_continue expected %0d actual %0d",
                   want.ident_continue, got.ident_continue);
            bad = 1'b1;
         end
         if (bad) fail_count++;
         char_count++;
         if (want.is_error) error_count++;
         if (want.ident_start) start_count++;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_byte_in;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [CP_W-1:0]  rsp_code_point;
   logic [LEN_W-1:0] rsp_seq_length;
   logic             rsp_is_error;
   logic             rsp_ident_start;
   logic             rsp_ident_continue;

   utf8_char_scoreboard sb;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_left;
   int          bytes_sent;
   logic [7:0]  seq_bytes [$];

   utf8_decoder_ident_classifier DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_seq_length     (rsp_seq_length),
      .rsp_is_error       (rsp_is_error),
      .rsp_ident_start    (rsp_ident_start),
      .rsp_ident_continue (rsp_ident_continue)
   );

   always #6 clock = ~clock;

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("utf8_decoder_ident_classifier: mismatch");
      $finish;
   end

   // receiver: random stall, or a long hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // output beat check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char(decoded_char_type'{rsp_code_point, rsp_seq_length, rsp_is_error,
                                          rsp_ident_start, rsp_ident_continue});
   end

   // offer one byte, with random idle cycles first; returns at the falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // stop offering until every owed character has come out
   task automatic drain_chars();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // shortest utf-8 form of a code point
   task automatic encode_cp(input logic [CP_W-1:0] cp);
      if (cp < 21'h80) begin
         seq_bytes.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         seq_bytes.push_back({3'b110, cp[10:6]});
         seq_bytes.push_back({CONT_TAG, cp[5:0]});
      end else if (cp < 21'h10000) begin
         seq_bytes.push_back({4'b1110, cp[15:12]});
         seq_bytes.push_back({CONT_TAG, cp[11:6]});
         seq_bytes.push_back({CONT_TAG, cp[5:0]});
      end else begin
         seq_bytes.push_back({5'b11110, cp[20:18]});
         seq_bytes.push_back({CONT_TAG, cp[17:12]});
         seq_bytes.push_back({CONT_TAG, cp[11:6]});
         seq_bytes.push_back({CONT_TAG, cp[5:0]});
      end
   endtask

   // one random chunk: well-formed sequences, range edges, raw noise, cut-off sequences
   task automatic build_chunk();
      int pick;
      int len;
      int idx;
      int k;
      logic [CP_W-1:0] cp;
      logic [15:0] low;
      seq_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 40) begin
         len = $urandom_range(1, 4);
         case (len)
            1: seq_bytes.push_back(8'($urandom_range(0, 127)));
            2: seq_bytes.push_back({3'b110, 5'($urandom)});
            3: seq_bytes.push_back({4'b1110, 4'($urandom)});
            default: seq_bytes.push_back({4'b1111, 4'($urandom)});
         endcase
         for (int i = 1; i < len; i++) seq_bytes.push_back({CONT_TAG, 6'($urandom)});
      end else if (pick < 70) begin
         // just inside and just outside an identifier range
         k = $urandom_range(0, 3);
         case ($urandom_range(0, 2))
            0: begin
               idx = $urandom_range(0, BMP_START_N - 1);
               cp  = (k < 2) ? CP_W'(BMP_START[idx][0]) : CP_W'(BMP_START[idx][1]);
            end
            1: begin
               idx = $urandom_range(0, CONT_ONLY_N - 1);
               cp  = (k < 2) ? CP_W'(CONT_ONLY[idx][0]) : CP_W'(CONT_ONLY[idx][1]);
            end
            default: begin
               k   = $urandom_range(0, 5);
               low = (k < 2) ? 16'(k) : 16'(16'hFFFA + k);
               cp  = {5'($urandom_range(0, 31)), low};
               k   = 1;
            end
         endcase
         if (k == 0) cp = cp - 1'b1;
         if (k == 3) cp = cp + 1'b1;
         encode_cp(cp);
      end else if (pick < 85) begin
         seq_bytes.push_back(8'($urandom));
      end else begin
         len = $urandom_range(2, 4);
         case (len)
            2: seq_bytes.push_back({3'b110, 5'($urandom)});
            3: seq_bytes.push_back({4'b1110, 4'($urandom)});
            default: seq_bytes.push_back({4'b1111, 4'($urandom)});
         endcase
         k = $urandom_range(0, len - 2);
         for (int i = 0; i < k; i++) seq_bytes.push_back({CONT_TAG, 6'($urandom)});
      end
   endtask

   task automatic send_random(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         build_chunk();
         foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
      end
   endtask

   // stimulus and end of run
   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_byte_in   = 8'h00;
      send_idle_pct = 23;
      recv_idle_pct = 61;
      hold_left     = 0;
      bytes_sent    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender light, receiver heavy
      for (int i = 0; i < DIRECTED_N; i++) send_byte(DIRECTED_BYTES[i]);
      send_random(610);
      drain_chars();

      // swapped, with a long output hold-off so the pipe backs up
      send_idle_pct = 61;
      recv_idle_pct = 23;
      hold_left     = 90;
      send_random(630);
      drain_chars();

      // back to back, another hold-off while bytes keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(300);
      hold_left = 60;
      send_random(335);
      drain_chars();

      $display("run covered %0d input bytes and %0d characters out (%0d error results)",
               bytes_sent, sb.char_count, sb.error_count);
      $display("%0d identifier starts seen, under three stall mixes and two long hold-offs",
               sb.start_count);
      if (sb.fail_count == 0) begin
         $display("utf8_decoder_ident_classifier: match");
      end else begin
         $display("utf8_decoder_ident_classifier: mismatch");
      end
      $finish;
   end

endmodule
